// ===== hdl/sorted_set_union_intersection_macros.svh =====
// Assertion macros used by the checker file of the sorted set block.
// Both expect i_clk, and SSEU_ASSERT also i_rst_n, to be visible where used.
`ifndef SORTED_SET_UNION_INTERSECTION_MACROS_SVH
`define SORTED_SET_UNION_INTERSECTION_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define SSEU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define SSEU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hdl/sseu_pkg.sv =====
// Package for the sorted set union/intersection block.
// Holds widths, operation and status codes and the compare result type.
// No dependencies.
package sseu_pkg;

    localparam int SSEU_CAPACITY = 16;
    localparam int DATA_W        = 32;
    localparam int MODE_W        = 3;
    localparam int STAT_W        = 3;

    // Operation codes carried on the input tuser.
    localparam logic [MODE_W-1:0] MODE_INS_A = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_B = 3'd1;
    localparam logic [MODE_W-1:0] MODE_UNION = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ISECT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    // Result status codes carried on the output tuser.
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] ST_ELEM     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp;

endpackage

// ===== hdl/sseu_mem.sv =====
// Set storage: one write port and one registered read port.
// Depends on nothing; instantiated once per set by the top level.
module sseu_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/sseu_cmp.sv =====
// Shared signed comparator used by both the insert search and the merge walk.
// Depends on sseu_pkg for the compare result type.
module sseu_cmp (
    input  logic [sseu_pkg::DATA_W-1:0] i_a,
    input  logic [sseu_pkg::DATA_W-1:0] i_b,
    output sseu_pkg::t_cmp              o_cmp
);
    import sseu_pkg::*;

    assign o_cmp.eq = (i_a == i_b);
    assign o_cmp.lt = ($signed(i_a) < $signed(i_b));

endmodule

// ===== hdl/sorted_set_union_intersection.sv =====
// Top level of the sorted set union/intersection block: sequencer, two set
// memories and one shared comparator. Depends on sseu_pkg, sseu_mem, sseu_cmp.
//
// Usage: the slave stream carries one command per transfer. tuser selects
// insert into A, insert into B, union, intersection or clear; tdata carries
// the signed value for inserts. Codes 5 to 7 are consumed and ignored.
// The master stream returns results: tdata is the element (zero otherwise),
// tuser the status, tlast marks the final result of a command.
// Steps from accepting a command to loading its result (na, nb: set counts):
//   insert: one compare step per entry passed plus one, one shift step per
//           entry moved, then the write, then the result.
//   union/intersection: one merge step per cycle unless a stalled output
//           halts it; na + nb steps at most, an end check, then the result;
//           an element goes out when the next kept one is found.
//   clear: empties both sets, then the result.
// The block takes one command at a time; o_s_axis_tready is high only while
// it is idle. A finished result sits in the output register and the block
// may take the next command meanwhile; a stalled receiver halts the merge
// walk. Reset empties both sets and drops any pending result; no clearing
// pass is needed since stored entries are only read below the count.
module sorted_set_union_intersection #(
    parameter int CAPACITY = sseu_pkg::SSEU_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [sseu_pkg::DATA_W-1:0] i_s_axis_tdata,   // [31:0] value
    input  logic [sseu_pkg::MODE_W-1:0] i_s_axis_tuser,   // [2:0] mode
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [sseu_pkg::DATA_W-1:0] o_m_axis_tdata,   // [31:0] result_value
    output logic [sseu_pkg::STAT_W-1:0] o_m_axis_tuser,   // [2:0] status
    output logic                        o_m_axis_tlast
);
    import sseu_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_MERGE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CNT_W-1:0]  r_pos, n_pos, r_k, n_k, r_i, n_i, r_j, n_j;
    logic [DATA_W-1:0] r_val, n_val, r_hold, n_hold;
    logic [STAT_W-1:0] r_status, n_status;
    logic              r_sel, n_sel, r_isect, n_isect, r_any, n_any;

    logic              r_ovalid;
    logic [DATA_W-1:0] r_odata;
    logic [STAT_W-1:0] r_ouser;
    logic              r_olast;

    logic              out_free, load_out;
    logic [DATA_W-1:0] out_data;
    logic [STAT_W-1:0] out_user;
    logic              out_last;

    logic [CNT_W-1:0]  cnt_sel, k_m1;
    logic [IDX_W-1:0]  seq_addr, rd_addr_a, rd_addr_b, wr_addr;
    logic [DATA_W-1:0] rd_a, rd_b, rd_sel, wr_data, op_a, op_b, pick_val;
    logic              wr_en_a, wr_en_b, wr_go;
    logic              has_a, has_b, take, adv_a, adv_b;
    t_cmp              cmp;

    sseu_mem #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_mem_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_a),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (rd_a)
    );

    sseu_mem #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_mem_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en_b),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (rd_b)
    );

    sseu_cmp u_cmp (
        .i_a   (op_a),
        .i_b   (op_b),
        .o_cmp (cmp)
    );

    assign cnt_sel  = r_sel ? r_cnt_b : r_cnt_a;
    assign rd_sel   = r_sel ? rd_b : rd_a;
    assign op_a     = (r_state == S_MERGE) ? rd_a : r_val;
    assign op_b     = (r_state == S_MERGE) ? rd_b : rd_sel;
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign has_a    = (r_i < r_cnt_a);
    assign has_b    = (r_j < r_cnt_b);

    // Merge step: which side advances and whether the value is kept.
    always_comb begin
        take     = 1'b0;
        adv_a    = 1'b0;
        adv_b    = 1'b0;
        pick_val = rd_a;
        if (has_a && has_b) begin
            if (cmp.eq) begin
                adv_a = 1'b1;
                adv_b = 1'b1;
                take  = 1'b1;
            end else if (cmp.lt) begin
                adv_a = 1'b1;
                take  = !r_isect;
            end else begin
                adv_b    = 1'b1;
                pick_val = rd_b;
                take     = !r_isect;
            end
        end else if (has_a) begin
            adv_a = 1'b1;
            take  = !r_isect;
        end else if (has_b) begin
            adv_b    = 1'b1;
            pick_val = rd_b;
            take     = !r_isect;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt_a  = r_cnt_a;
        n_cnt_b  = r_cnt_b;
        n_pos    = r_pos;
        n_k      = r_k;
        n_i      = r_i;
        n_j      = r_j;
        n_val    = r_val;
        n_hold   = r_hold;
        n_status = r_status;
        n_sel    = r_sel;
        n_isect  = r_isect;
        n_any    = r_any;
        load_out = 1'b0;
        out_data = r_hold;
        out_user = ST_ELEM;
        out_last = 1'b0;
        wr_go    = 1'b0;
        wr_data  = r_val;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_val  = i_s_axis_tdata;
                    n_hold = '0;
                    n_any  = 1'b0;
                    n_pos  = '0;
                    n_i    = '0;
                    n_j    = '0;
                    unique case (i_s_axis_tuser) inside
                        MODE_INS_A, MODE_INS_B: begin
                            n_sel   = (i_s_axis_tuser == MODE_INS_B);
                            n_state = S_SEARCH;
                        end
                        MODE_UNION, MODE_ISECT: begin
                            n_isect = (i_s_axis_tuser == MODE_ISECT);
                            n_state = S_MERGE;
                        end
                        MODE_CLEAR: begin
                            n_cnt_a  = '0;
                            n_cnt_b  = '0;
                            n_status = ST_CLEARED;
                            n_state  = S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_SEARCH: begin
                // The equality search runs before the capacity check.
                if (r_pos != cnt_sel && cmp.eq) begin
                    n_status = ST_DUP;
                    n_state  = S_DONE;
                end else if (r_pos == cnt_sel || cmp.lt) begin
                    if (cnt_sel == CNT_FULL) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_k     = cnt_sel;
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_pos = r_pos + CNT_ONE;
                end
            end
            S_SHIFT: begin
                wr_go = 1'b1;
                if (r_k == r_pos) begin
                    wr_data  = r_val;
                    n_status = ST_INSERTED;
                    n_state  = S_DONE;
                    if (r_sel) begin
                        n_cnt_b = r_cnt_b + CNT_ONE;
                    end else begin
                        n_cnt_a = r_cnt_a + CNT_ONE;
                    end
                end else begin
                    wr_data = rd_sel;
                    n_k     = r_k - CNT_ONE;
                end
            end
            S_MERGE: begin
                if (!has_a && !has_b) begin
                    n_status = r_any ? ST_ELEM : ST_EMPTY;
                    n_state  = S_DONE;
                end else if (!(take && r_any && !out_free)) begin
                    // One element is held back so that tlast can go on the final one.
                    n_i = r_i + CNT_W'(adv_a);
                    n_j = r_j + CNT_W'(adv_b);
                    if (take) begin
                        load_out = r_any;
                        n_hold   = pick_val;
                        n_any    = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_user = r_status;
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign k_m1      = n_k - CNT_ONE;
    assign seq_addr  = (n_state == S_SHIFT) ? k_m1[IDX_W-1:0] : n_pos[IDX_W-1:0];
    assign rd_addr_a = (n_state == S_MERGE) ? n_i[IDX_W-1:0] : seq_addr;
    assign rd_addr_b = (n_state == S_MERGE) ? n_j[IDX_W-1:0] : seq_addr;
    assign wr_addr   = r_k[IDX_W-1:0];
    assign wr_en_a   = wr_go && !r_sel;
    assign wr_en_b   = wr_go && r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_i      <= n_i;
        r_j      <= n_j;
        r_val    <= n_val;
        r_hold   <= n_hold;
        r_status <= n_status;
        r_sel    <= n_sel;
        r_isect  <= n_isect;
        r_any    <= n_any;
        if (load_out) begin
            r_odata <= out_data;
            r_ouser <= out_user;
            r_olast <= out_last;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
    assign o_m_axis_tlast  = r_olast;

endmodule

// ===== hdl/sseu_checker.sv =====
// Port-level checker for the sorted set union/intersection block, bound to it.
// Depends on sseu_pkg and sorted_set_union_intersection_macros.svh.
`include "sorted_set_union_intersection_macros.svh"

module sseu_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_axis_tvalid,
    input logic                        o_s_axis_tready,
    input logic [sseu_pkg::DATA_W-1:0] i_s_axis_tdata,
    input logic [sseu_pkg::MODE_W-1:0] i_s_axis_tuser,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [sseu_pkg::DATA_W-1:0] o_m_axis_tdata,
    input logic [sseu_pkg::STAT_W-1:0] o_m_axis_tuser,
    input logic                        o_m_axis_tlast
);
    import sseu_pkg::*;

    logic [DATA_W+STAT_W:0] out_beat;
    logic                   out_stall;
    logic                   lone_zero;
    logic                   cmd_taken;

    assign out_beat  = {o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast};
    assign out_stall = o_m_axis_tvalid && !i_m_axis_tready;
    assign lone_zero = o_m_axis_tlast && (o_m_axis_tdata == '0);
    assign cmd_taken = i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser <= MODE_CLEAR);

    `SSEU_ASSERT_ALWAYS(a_rst_no_out, !i_rst_n |=> !o_m_axis_tvalid, "result valid after reset")
    `SSEU_ASSERT(a_out_hold, out_stall |=> o_m_axis_tvalid && $stable(out_beat), "stalled result changed")
    `SSEU_ASSERT(a_status_range, o_m_axis_tvalid |-> o_m_axis_tuser <= ST_CLEARED, "status out of range")
    `SSEU_ASSERT(a_single_result, o_m_axis_tvalid && o_m_axis_tuser != ST_ELEM |-> lone_zero, "lone result")
    `SSEU_ASSERT(a_busy_after_cmd, cmd_taken |=> !o_s_axis_tready, "ready right after a command")

endmodule

bind sorted_set_union_intersection sseu_checker u_sseu_checker (.*);
